@@ hw/rtl/cjkng_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CJK n-gram span emitter package
// Shared widths, codes and the item, job and result types of the emitter.
// ----------------------------------------------------------------------------
package cjkng_pkg;

  localparam int MAX_NGRAM   = 4;
  localparam int CNT_W       = $clog2(MAX_NGRAM + 2);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W   = 2;
  localparam int CP_W   = 21;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 3;
  localparam int POS_W  = 32;
  localparam int NG_W   = 3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 3;

  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_PAD_W  = 3;
  localparam int OUT_USER_W = 1;

  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_NGRAM_LEN  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ONLY_SPANS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NO_SPANS   = 2'd2;

  localparam logic [NG_W-1:0] NGRAM_LEN_RESET = 3'd2;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [CP_W-1:0] CH_UPPER_A    = 21'd65;
  localparam logic [CP_W-1:0] CH_UPPER_Z    = 21'd90;
  localparam logic [CP_W-1:0] CH_LOWER_A    = 21'd97;
  localparam logic [CP_W-1:0] CH_LOWER_Z    = 21'd122;
  localparam logic [CP_W-1:0] CH_LATIN1_MAX = 21'd255;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [CP_W-1:0]  code_point;
    logic             is_cjk;
    logic             is_space;
    logic [OFF_W-1:0] byte_pos;
    logic [LEN_W-1:0] byte_len;
    logic [POS_W-1:0] start_word_pos;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]                nwords;
    logic [CNT_W-1:0]                nres;
    logic [MAX_NGRAM-1:0][OFF_W-1:0] starts;
    logic [OFF_W-1:0]                word_end;
    logic [POS_W-1:0]                wp_first;
    logic [CP_W-1:0]                 stop_char;
    logic [POS_W-1:0]                next_wp;
  } job_t;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] word_start;
    logic [OFF_W-1:0] word_end;
    logic [POS_W-1:0] word_pos;
    logic [CP_W-1:0]  stop_char;
    logic [POS_W-1:0] next_word_pos;
    logic             last;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/cjk_ngram_span_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CJK n-gram span emitter
// Splits a span of classified characters into character n-gram words.
// ----------------------------------------------------------------------------
// Words enter on the s_axis channel: begin span, character or end of text.
// In the default mode each character yields the byte range and position of
// every n-gram ending at it; a stop character or end of text yields a
// finished result, preceded by a flushed partial span in only-spans mode.
// Results leave on m_axis, tlast marking the last result caused by one
// input word. The front end takes one input word per cycle while the
// two-entry job queue has room. The back end sends one result per cycle
// while the m_axis receiver is ready. The first result of a word passes
// through the queue entry, the back end's job register and the output
// register. Configuration must be written through cfg_we, cfg_addr and
// cfg_wdata while idle; the block itself does not enforce this.
// Reset (rst, synchronous) empties the queue and output stage, clears the
// span state and sets ngram_len to 2 with both mode flags off.
// A stalled m_axis receiver holds the output register; the queue then fills
// and s_axis_tready drops until results drain.
// ----------------------------------------------------------------------------
module cjk_ngram_span_emitter
  import cjkng_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // code_point[20:0], byte_pos[52:21], byte_len[55:53], start_word_pos[87:56]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0], is_cjk[2], is_space[3]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // word_start[31:0], word_end[63:32], word_pos[95:64], stop_char[116:96],
  // next_word_pos[148:117], zero fill[151:149]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind[0]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  item_t   in_item;
  job_t    fe_job;
  job_t    q_job;
  result_t res;
  logic    fe_job_valid, fe_job_ready, q_job_valid, q_job_ready;

  always_comb begin
    in_item.operation      = s_axis_tuser[1:0];
    in_item.is_cjk         = s_axis_tuser[2];
    in_item.is_space       = s_axis_tuser[3];
    in_item.code_point     = s_axis_tdata[20:0];
    in_item.byte_pos       = s_axis_tdata[52:21];
    in_item.byte_len       = s_axis_tdata[55:53];
    in_item.start_word_pos = s_axis_tdata[87:56];
  end

  cjkng_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .job_valid (fe_job_valid),
    .job_ready (fe_job_ready),
    .job       (fe_job)
  );

  cjkng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_job_valid),
    .in_ready  (fe_job_ready),
    .in_job    (fe_job),
    .out_valid (q_job_valid),
    .out_ready (q_job_ready),
    .out_job   (q_job)
  );

  cjkng_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_job_valid),
    .job_ready (q_job_ready),
    .job       (q_job),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {OUT_PAD_W'(0), res.next_word_pos, res.stop_char, res.word_pos,
                         res.word_end, res.word_start};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // A finished result always closes the results of its input word.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] == KIND_FINISH |-> m_axis_tlast)
    else $error("finished result not marked last");

  // Word results carry no stop character and no next word position.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] == KIND_WORD |->
      m_axis_tdata[116:96] == '0 && m_axis_tdata[148:117] == '0)
    else $error("word result carries span fields");

  // Reset leaves nothing on the output.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

@@ hw/rtl/cjkng_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CJK n-gram front end
// Holds the configuration and span state, classifies each word and turns it
// into a job that describes the results it causes.
// ----------------------------------------------------------------------------
module cjkng_front
  import cjkng_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  item_t                 in_item,
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);

  logic [NG_W-1:0]  ngram_len;
  logic             only_spans;
  logic             no_spans;

  logic [OFF_W-1:0] win      [MAX_NGRAM];
  logic [OFF_W-1:0] win_next [MAX_NGRAM];
  logic [OFF_W-1:0] win_app  [MAX_NGRAM];
  logic [CNT_W-1:0] fill, fill_next;
  logic             space_before, space_before_next;
  logic [POS_W-1:0] word_position, word_position_next;
  logic [CP_W-1:0]  last_char, last_char_next;
  logic             span_active, span_active_next;

  logic [CNT_W-1:0] n_eff, drop, fill_base, fill_app, lb, le, nwords_char;
  logic             accept, is_alpha, is_stop, emit, flush, finish_req, word_req;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (ngram_len == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(ngram_len) > MAX_NGRAM) begin
      n_eff = CNT_W'(MAX_NGRAM);
    end else begin
      n_eff = CNT_W'(ngram_len);
    end
  end

  always_comb begin
    if (fill >= n_eff) begin
      drop      = fill - n_eff + CNT_W'(1);
      fill_base = n_eff - CNT_W'(1);
    end else begin
      drop      = '0;
      fill_base = fill;
    end
    fill_app = fill_base + CNT_W'(1);
    for (int i = 0; i < MAX_NGRAM; i++) begin
      win_app[i] = win[i];
      for (int d = 1; d < MAX_NGRAM; d++) begin
        if (int'(drop) == d && i + d < MAX_NGRAM) begin
          win_app[i] = win[(i + d) % MAX_NGRAM];
        end
      end
      if (int'(fill_base) == i) begin
        win_app[i] = in_item.byte_pos;
      end
    end
  end

  always_comb begin
    is_alpha = (in_item.code_point >= CH_UPPER_A && in_item.code_point <= CH_UPPER_Z) ||
               (in_item.code_point >= CH_LOWER_A && in_item.code_point <= CH_LOWER_Z);
    is_stop  = (space_before || in_item.code_point > CH_LATIN1_MAX || is_alpha) &&
               !in_item.is_cjk;
    emit     = !only_spans || (fill_app == n_eff);
    lb       = no_spans ? fill_app - CNT_W'(1) : '0;
    le       = only_spans ? CNT_W'(1) : fill_app;
    nwords_char = (emit && le > lb) ? le - lb : '0;
    flush    = only_spans && fill != '0 && fill != n_eff;
    finish_req = span_active &&
                 ((in_item.operation == OP_CHAR && is_stop) || in_item.operation == OP_END);
    word_req   = span_active && in_item.operation == OP_CHAR && !is_stop &&
                 !in_item.is_space;
  end

  always_comb begin
    job = '0;
    if (finish_req) begin
      job.nwords    = flush ? CNT_W'(1) : '0;
      job.nres      = job.nwords + CNT_W'(1);
      job.starts[0] = win[0];
      job.word_end  = in_item.byte_pos;
      job.wp_first  = word_position - POS_W'(fill);
      job.stop_char = (in_item.operation == OP_END) ? last_char : in_item.code_point;
      job.next_wp   = word_position;
    end else if (word_req) begin
      job.nwords   = nwords_char;
      job.nres     = nwords_char;
      for (int j = 0; j < MAX_NGRAM; j++) begin
        for (int i = 0; i < MAX_NGRAM; i++) begin
          if (int'(lb) + j == i) begin
            job.starts[j] = win_app[i];
          end
        end
      end
      job.word_end = in_item.byte_pos + OFF_W'(in_item.byte_len);
      job.wp_first = word_position - POS_W'(fill_app) + POS_W'(lb) + POS_W'(1);
    end
  end

  assign job_valid = in_valid && job.nres != '0;

  always_comb begin
    win_next           = win;
    fill_next          = fill;
    space_before_next  = space_before;
    word_position_next = word_position;
    last_char_next     = last_char;
    span_active_next   = span_active;
    case (in_item.operation)
      OP_BEGIN: begin
        fill_next          = '0;
        space_before_next  = 1'b0;
        word_position_next = in_item.start_word_pos;
        last_char_next     = '0;
        span_active_next   = 1'b1;
      end
      OP_CHAR: begin
        if (span_active) begin
          last_char_next = in_item.code_point;
          if (is_stop) begin
            span_active_next = 1'b0;
          end else if (in_item.is_space) begin
            fill_next         = '0;
            space_before_next = 1'b1;
          end else begin
            space_before_next  = 1'b0;
            win_next           = win_app;
            fill_next          = (only_spans && emit) ? '0 : fill_app;
            word_position_next = word_position + POS_W'(1);
          end
        end
      end
      OP_END: begin
        if (span_active) begin
          span_active_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_len     <= NGRAM_LEN_RESET;
      only_spans    <= 1'b0;
      no_spans      <= 1'b0;
      fill          <= '0;
      space_before  <= 1'b0;
      word_position <= '0;
      last_char     <= '0;
      span_active   <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_NGRAM_LEN) begin
        ngram_len <= cfg_wdata[NG_W-1:0];
      end
      if (cfg_we && cfg_addr == REG_ONLY_SPANS) begin
        only_spans <= cfg_wdata[0];
      end
      if (cfg_we && cfg_addr == REG_NO_SPANS) begin
        no_spans <= cfg_wdata[0];
      end
      if (accept) begin
        fill          <= fill_next;
        space_before  <= space_before_next;
        word_position <= word_position_next;
        last_char     <= last_char_next;
        span_active   <= span_active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cjkng_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CJK n-gram job queue
// A short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module cjkng_queue
  import cjkng_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign in_ready  = count != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cjkng_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CJK n-gram back end
// Expands one job at a time into its results, one per cycle while the
// output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module cjkng_back
  import cjkng_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  job_t             cur;
  logic             cur_valid;
  logic [CNT_W-1:0] idx;
  result_t          res_next;
  logic             out_load, is_last, cur_done;

  assign out_load  = cur_valid && (!out_valid || out_ready);
  assign is_last   = (idx + CNT_W'(1)) == cur.nres;
  assign cur_done  = out_load && is_last;
  assign job_ready = !cur_valid || cur_done;

  always_comb begin
    res_next      = '0;
    res_next.last = is_last;
    if (idx < cur.nwords) begin
      res_next.kind = KIND_WORD;
      for (int j = 0; j < MAX_NGRAM; j++) begin
        if (idx == CNT_W'(j)) begin
          res_next.word_start = cur.starts[j];
        end
      end
      res_next.word_end = cur.word_end;
      res_next.word_pos = cur.wp_first + POS_W'(idx);
    end else begin
      res_next.kind          = KIND_FINISH;
      res_next.stop_char     = cur.stop_char;
      res_next.next_word_pos = cur.next_wp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_res   <= res_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_valid && job_ready) begin
        cur       <= job;
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (out_load) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
